[rtl/rebd_pkg.sv]
// Package for the rotary encoder and push switch decoder.
// Holds the request types, event codes, register indexes and the quadrature table.
// No dependencies.
package rebd_pkg;

    typedef struct packed {
        logic a_level;
        logic b_level;
        logic sw_level;
        logic ms_tick;
    } in_item_t;

    typedef struct packed {
        logic [2:0] event_code;
        logic       button_pressed;
    } out_item_t;

    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_CW    = 3'd1;
    localparam logic [2:0] EV_CCW   = 3'd2;
    localparam logic [2:0] EV_SHORT = 3'd3;
    localparam logic [2:0] EV_LONG  = 3'd4;

    localparam int CfgIndexWidth = 3;
    localparam logic [CfgIndexWidth-1:0] REG_STEPS      = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_DEBOUNCE   = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_LONG       = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_AB_LOW     = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_SW_LOW     = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_FORCE_LOW  = 3'd5;

    localparam logic [3:0]  DEF_STEPS    = 4'd4;
    localparam logic [15:0] DEF_DEBOUNCE = 16'd20;
    localparam logic [15:0] DEF_LONG     = 16'd1000;

    // Step for each {previous A/B, current A/B} transition
    localparam logic signed [1:0] QUAD_TABLE [16] = '{
         2'sd0, -2'sd1,  2'sd1,  2'sd0,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

endpackage

[rtl/rotary_encoder_with_button_unit.sv]
// Rotary encoder decoder with debounced push switch, top level.
// Depends on rebd_pkg.
//
// Usage:
//   Each input request is one sample of the A, B and switch pins plus a flag
//   that one millisecond has passed since the previous sample. Every request
//   gives exactly one result: an event code (none, clockwise, counter-clockwise,
//   short press, long press) and the debounced switch state.
//   A request is taken when in_valid is high and in_stall is low; a result is
//   taken when out_valid is high and out_stall is low.
//   All decoding, the detent counts and the debounce timing are updated in the
//   accepting cycle, and the result is registered for the cycle after it.
//   Throughput is one request per cycle; the single result register is the
//   only buffering, so in_stall rises only while a result waits and the
//   receiver stalls, and a result that waits holds still.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
//   always ready; indexes above five are ignored. Write it only while idle.
//   Reset restores the register defaults and clears all state but the result data; the first
//   sample after reset only primes the stored pin and switch states.
module rotary_encoder_with_button_unit
    import rebd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  in_item_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output out_item_t                out_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [15:0]              cfg_data
);

    logic [3:0]  steps_reg;
    logic [15:0] debounce_reg;
    logic [15:0] long_reg;
    logic        ab_low_reg;
    logic        sw_low_reg;
    logic        force_low_reg;

    logic              primed_reg,        primed_next;
    logic [1:0]        prev_ab_reg,       prev_ab_next;
    logic signed [4:0] acc_reg,           acc_next;
    logic [7:0]        cw_reg,            cw_next;
    logic [7:0]        ccw_reg,           ccw_next;
    logic [31:0]       ms_reg,            ms_next;
    logic              sw_raw_reg,        sw_raw_next;
    logic              sw_stable_reg,     sw_stable_next;
    logic              pressing_reg,      pressing_next;
    logic              long_done_reg,     long_done_next;
    logic [31:0]       bounce_time_reg,   bounce_time_next;
    logic [31:0]       press_time_reg,    press_time_next;

    logic      out_valid_reg;
    out_item_t out_data_reg, out_data_next;

    logic              accept;
    logic              force_low, ab_low, sw_low;
    logic [3:0]        spd;
    logic [15:0]       deb, lng;
    logic [1:0]        cur_ab;
    logic              sw_act;
    logic signed [1:0] step;
    logic signed [4:0] acc_base;
    logic signed [5:0] sum;
    logic signed [5:0] spd_s;
    logic [2:0]        rot_event, btn_event;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        force_low = force_low_reg || (!ab_low_reg && !sw_low_reg);
        ab_low    = force_low || ab_low_reg;
        sw_low    = force_low || sw_low_reg;
        spd       = (steps_reg != 4'd0) ? steps_reg : DEF_STEPS;
        deb       = (debounce_reg != 16'd0) ? debounce_reg : DEF_DEBOUNCE;
        lng       = (long_reg != 16'd0) ? long_reg : DEF_LONG;
        spd_s     = $signed({2'b00, spd});

        ms_next = ms_reg + {31'd0, in_data.ms_tick};
        cur_ab  = {in_data.a_level ^ ab_low, in_data.b_level ^ ab_low};
        sw_act  = in_data.sw_level ^ sw_low;
        step    = QUAD_TABLE[{prev_ab_reg, cur_ab}];

        primed_next      = 1'b1;
        prev_ab_next     = cur_ab;
        acc_next         = acc_reg;
        cw_next          = cw_reg;
        ccw_next         = ccw_reg;
        sw_raw_next      = sw_raw_reg;
        sw_stable_next   = sw_stable_reg;
        pressing_next    = pressing_reg;
        long_done_next   = long_done_reg;
        bounce_time_next = bounce_time_reg;
        press_time_next  = press_time_reg;
        rot_event        = EV_NONE;
        btn_event        = EV_NONE;

        // Drop the partial sum on a change of direction
        if ((acc_reg > 5'sd0 && step < 2'sd0) || (acc_reg < 5'sd0 && step > 2'sd0))
        begin
            acc_base = 5'sd0;
        end
        else
        begin
            acc_base = acc_reg;
        end
        sum = {acc_base[4], acc_base} + {{4{step[1]}}, step};

        if (step != 2'sd0)
        begin
            if (sum >= spd_s)
            begin
                acc_next = 5'(sum - spd_s);
                if (cw_reg != 8'hff)
                begin
                    cw_next = cw_reg + 8'd1;
                end
            end
            else if (sum <= -spd_s)
            begin
                acc_next = 5'(sum + spd_s);
                if (ccw_reg != 8'hff)
                begin
                    ccw_next = ccw_reg + 8'd1;
                end
            end
            else
            begin
                acc_next = 5'(sum);
            end
        end

        // Pop one pending detent, clockwise first
        if (cw_next != 8'd0)
        begin
            cw_next   = cw_next - 8'd1;
            rot_event = EV_CW;
        end
        else if (ccw_next != 8'd0)
        begin
            ccw_next  = ccw_next - 8'd1;
            rot_event = EV_CCW;
        end

        if (sw_act != sw_raw_reg)
        begin
            sw_raw_next      = sw_act;
            bounce_time_next = ms_next;
        end
        if ((ms_next - bounce_time_next) >= {16'd0, deb} && sw_stable_reg != sw_raw_next)
        begin
            sw_stable_next = sw_raw_next;
            if (sw_raw_next)
            begin
                pressing_next   = 1'b1;
                long_done_next  = 1'b0;
                press_time_next = ms_next;
            end
            else if (pressing_reg)
            begin
                pressing_next = 1'b0;
                if (!long_done_reg)
                begin
                    btn_event = EV_SHORT;
                end
            end
        end
        if (pressing_next && sw_stable_next && !long_done_next &&
            (ms_next - press_time_next) >= {16'd0, lng})
        begin
            long_done_next = 1'b1;
            btn_event      = EV_LONG;
        end

        out_data_next.event_code     = (btn_event != EV_NONE) ? btn_event : rot_event;
        out_data_next.button_pressed = sw_stable_next;

        // First sample only primes the stored states
        if (!primed_reg)
        begin
            acc_next         = 5'sd0;
            cw_next          = 8'd0;
            ccw_next         = 8'd0;
            sw_raw_next      = sw_act;
            sw_stable_next   = sw_act;
            pressing_next    = sw_act;
            long_done_next   = 1'b0;
            bounce_time_next = ms_next;
            press_time_next  = ms_next;
            out_data_next.event_code     = EV_NONE;
            out_data_next.button_pressed = sw_act;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg     <= DEF_STEPS;
            debounce_reg  <= DEF_DEBOUNCE;
            long_reg      <= DEF_LONG;
            ab_low_reg    <= 1'b1;
            sw_low_reg    <= 1'b1;
            force_low_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_STEPS:     steps_reg     <= cfg_data[3:0];
                REG_DEBOUNCE:  debounce_reg  <= cfg_data;
                REG_LONG:      long_reg      <= cfg_data;
                REG_AB_LOW:    ab_low_reg    <= cfg_data[0];
                REG_SW_LOW:    sw_low_reg    <= cfg_data[0];
                REG_FORCE_LOW: force_low_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg      <= 1'b0;
            prev_ab_reg     <= 2'b00;
            acc_reg         <= 5'sd0;
            cw_reg          <= 8'd0;
            ccw_reg         <= 8'd0;
            ms_reg          <= 32'd0;
            sw_raw_reg      <= 1'b0;
            sw_stable_reg   <= 1'b0;
            pressing_reg    <= 1'b0;
            long_done_reg   <= 1'b0;
            bounce_time_reg <= 32'd0;
            press_time_reg  <= 32'd0;
        end
        else if (accept)
        begin
            primed_reg      <= primed_next;
            prev_ab_reg     <= prev_ab_next;
            acc_reg         <= acc_next;
            cw_reg          <= cw_next;
            ccw_reg         <= ccw_next;
            ms_reg          <= ms_next;
            sw_raw_reg      <= sw_raw_next;
            sw_stable_reg   <= sw_stable_next;
            pressing_reg    <= pressing_next;
            long_done_reg   <= long_done_next;
            bounce_time_reg <= bounce_time_next;
            press_time_reg  <= press_time_next;
        end
    end

    // Hold the result while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

[rtl/rebd_checker.sv]
// Port-level checks for the rotary encoder and push switch decoder.
// Depends on rebd_pkg; bound to rotary_encoder_with_button_unit.
module rebd_checker
    import rebd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    a_one_cycle : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted request gave no result next cycle");

    a_no_idle_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while result register empty");

    a_code_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.event_code <= EV_LONG)
        else $error("event code out of range");

    a_press_state : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.event_code == EV_SHORT || out_data.event_code == EV_LONG)
        |-> out_data.button_pressed == (out_data.event_code == EV_LONG))
        else $error("press event disagrees with switch state");

endmodule

bind rotary_encoder_with_button_unit rebd_checker u_rebd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

[tb/tb_rotary_encoder_with_button_unit.sv]
`timescale 1ns / 1ps
// Testbench for the rotary encoder and push switch decoder: directed pin sequences,
// then random quadrature and switch traffic with random stalls on both channels.
// Depends on rebd_pkg and rotary_encoder_with_button_unit.
module tb_rotary_encoder_with_button_unit;
    import rebd_pkg::*;

    localparam int QuietLimit    = 2000;
    localparam int HoldOffCycles = 160;

    localparam logic [CfgIndexWidth-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CfgIndexWidth-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [3:0]  STEPS_FALLBACK    = 4'd4;
    localparam logic [15:0] DEBOUNCE_FALLBACK = 16'd20;
    localparam logic [15:0] LONG_FALLBACK     = 16'd1000;

    // Step for each {previous A/B, current A/B} pair of active levels
    localparam int QuadStep [16] = '{
         0, -1,  1,  0,
         1,  0,  0, -1,
        -1,  0,  0,  1,
         0,  1, -1,  0
    };

    class rebd_event_tracker;
        logic [3:0]        steps_reg;
        logic [15:0]       debounce_reg;
        logic [15:0]       long_reg;
        logic              ab_low_reg;
        logic              sw_low_reg;
        logic              force_reg;

        logic              primed;
        logic [1:0]        prev_ab;
        logic signed [4:0] detent_sum;
        logic [7:0]        cw_pend;
        logic [7:0]        ccw_pend;
        logic [31:0]       ms_count;
        logic              sw_raw;
        logic              sw_stable;
        logic              pressing;
        logic              long_done;
        logic [31:0]       bounce_stamp;
        logic [31:0]       press_stamp;

        out_item_t         pending_events[$];
        int                mismatch_count;

        function new();
            steps_reg      = STEPS_FALLBACK;
            debounce_reg   = DEBOUNCE_FALLBACK;
            long_reg       = LONG_FALLBACK;
            ab_low_reg     = 1'b1;
            sw_low_reg     = 1'b1;
            force_reg      = 1'b0;
            primed         = 1'b0;
            prev_ab        = 2'b00;
            detent_sum     = '0;
            cw_pend        = '0;
            ccw_pend       = '0;
            ms_count       = '0;
            sw_raw         = 1'b0;
            sw_stable      = 1'b0;
            pressing       = 1'b0;
            long_done      = 1'b0;
            bounce_stamp   = '0;
            press_stamp    = '0;
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [CfgIndexWidth-1:0] idx, logic [15:0] value);
            case (idx)
                REG_STEPS:     steps_reg    = value[3:0];
                REG_DEBOUNCE:  debounce_reg = value;
                REG_LONG:      long_reg     = value;
                REG_AB_LOW:    ab_low_reg   = value[0];
                REG_SW_LOW:    sw_low_reg   = value[0];
                REG_FORCE_LOW: force_reg    = value[0];
                default:       ;
            endcase
        endfunction

        function void note_sample(in_item_t smp);
            logic              use_force;
            logic              ab_low;
            logic              sw_low;
            logic [1:0]        cur_ab;
            logic              sw_act;
            logic [31:0]       now;
            logic [31:0]       deb;
            logic [31:0]       lng;
            logic signed [4:0] spd;
            int                step;
            logic [2:0]        ev_code;
            logic [2:0]        button_code;
            out_item_t         res;

            use_force = force_reg || (!ab_low_reg && !sw_low_reg);
            ab_low    = use_force || ab_low_reg;
            sw_low    = use_force || sw_low_reg;
            deb = {16'd0, (debounce_reg != 16'd0) ? debounce_reg : DEBOUNCE_FALLBACK};
            lng = {16'd0, (long_reg != 16'd0) ? long_reg : LONG_FALLBACK};
            spd = (steps_reg != 4'd0) ? $signed({1'b0, steps_reg})
                                      : $signed({1'b0, STEPS_FALLBACK});

            if (smp.ms_tick)
                ms_count = ms_count + 32'd1;
            now         = ms_count;
            cur_ab      = {smp.a_level ^ ab_low, smp.b_level ^ ab_low};
            sw_act      = smp.sw_level ^ sw_low;
            ev_code     = EV_NONE;
            button_code = EV_NONE;

            if (!primed)
            begin
                primed       = 1'b1;
                prev_ab      = cur_ab;
                detent_sum   = '0;
                cw_pend      = '0;
                ccw_pend     = '0;
                sw_raw       = sw_act;
                sw_stable    = sw_act;
                pressing     = sw_act;
                long_done    = 1'b0;
                bounce_stamp = now;
                press_stamp  = now;
            end
            else
            begin
                step    = QuadStep[{prev_ab, cur_ab}];
                prev_ab = cur_ab;
                if (step != 0)
                begin
                    // drop a partial detent when the direction reverses
                    if ((detent_sum > 0 && step < 0) || (detent_sum < 0 && step > 0))
                        detent_sum = '0;
                    detent_sum = 5'(detent_sum + step);
                    if (detent_sum >= spd)
                    begin
                        detent_sum = detent_sum - spd;
                        if (cw_pend != 8'hFF)
                            cw_pend = cw_pend + 8'd1;
                    end
                    else if (detent_sum <= -spd)
                    begin
                        detent_sum = detent_sum + spd;
                        if (ccw_pend != 8'hFF)
                            ccw_pend = ccw_pend + 8'd1;
                    end
                end

                if (cw_pend != 8'd0)
                begin
                    cw_pend = cw_pend - 8'd1;
                    ev_code = EV_CW;
                end
                else if (ccw_pend != 8'd0)
                begin
                    ccw_pend = ccw_pend - 8'd1;
                    ev_code  = EV_CCW;
                end

                if (sw_act != sw_raw)
                begin
                    sw_raw       = sw_act;
                    bounce_stamp = now;
                end
                if ((now - bounce_stamp) >= deb && sw_stable != sw_raw)
                begin
                    sw_stable = sw_raw;
                    if (sw_stable)
                    begin
                        pressing    = 1'b1;
                        long_done   = 1'b0;
                        press_stamp = now;
                    end
                    else if (pressing)
                    begin
                        pressing = 1'b0;
                        if (!long_done)
                            button_code = EV_SHORT;
                    end
                end
                if (pressing && sw_stable && !long_done && (now - press_stamp) >= lng)
                begin
                    long_done   = 1'b1;
                    button_code = EV_LONG;
                end
                // a button event replaces the rotation popped on this sample
                if (button_code != EV_NONE)
                    ev_code = button_code;
            end

            res.event_code     = ev_code;
            res.button_pressed = sw_stable;
            pending_events.push_back(res);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] result check: %s", $realtime, what);
            mismatch_count++;
        endtask

        task check_event(out_item_t got);
            out_item_t want;
            if (pending_events.size() == 0)
            begin
                report_mismatch($sformatf("result %0h arrived with nothing pending", got));
                return;
            end
            want = pending_events.pop_front();
            if (got.event_code !== want.event_code)
                report_mismatch($sformatf("event_code got %0d want %0d",
                                          got.event_code, want.event_code));
            if (got.button_pressed !== want.button_pressed)
                report_mismatch($sformatf("button_pressed got %0b want %0b",
                                          got.button_pressed, want.button_pressed));
        endtask
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    in_item_t                 in_data;
    logic                     out_valid;
    logic                     out_stall;
    out_item_t                out_data;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [15:0]              cfg_data;

    rebd_event_tracker tracker = new();
    int                sent_count = 0;

    // Random pin generator state
    int   enc_pos     = 0;
    int   enc_dir     = 1;
    logic sw_hold     = 1'b1;
    int   sw_run_left = 0;
    int   sw_run_max  = 20;

    rotary_encoder_with_button_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic calm_window();
        return sent_count >= 1100 && sent_count < 1400;
    endfunction

    function automatic in_item_t next_sample();
        in_item_t smp;
        int       roll;
        roll = $urandom_range(99);
        // a tenth of the traffic is plain noise on all four pins
        if (roll < 10)
        begin
            smp = 4'($urandom_range(15));
            return smp;
        end
        roll = $urandom_range(99);
        if (roll < 6)
            enc_dir = -enc_dir;
        if (roll < 60)
            enc_pos = (enc_pos + enc_dir + 4) % 4;
        else if (roll < 64)
            enc_pos = (enc_pos + 2) % 4;
        if (sw_run_left == 0)
        begin
            sw_hold     = ~sw_hold;
            sw_run_left = $urandom_range(1, sw_run_max);
        end
        sw_run_left--;
        smp.a_level  = enc_pos[1] ^ enc_pos[0];
        smp.b_level  = enc_pos[1];
        // chatter on the switch contact now and then
        smp.sw_level = ($urandom_range(99) < 5) ? ~sw_hold : sw_hold;
        smp.ms_tick  = ($urandom_range(99) < 85);
        return smp;
    endfunction

    task automatic send_request(input in_item_t req);
        if (!calm_window() && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 26)
                @(posedge clk);
        end
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_sample(req);
        sent_count++;
    endtask

    task automatic send_pins(input logic a, input logic b, input logic sw, input logic tick);
        in_item_t smp;
        smp.a_level  = a;
        smp.b_level  = b;
        smp.sw_level = sw;
        smp.ms_tick  = tick;
        send_request(smp);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending_events.size() != 0);
    endtask

    task automatic write_word(input logic [CfgIndexWidth-1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.write_reg(idx, value);
    endtask

    // Narrow registers get random upper bits, which must be ignored
    task automatic apply_settings(input logic [3:0] steps, input logic [15:0] deb,
                                  input logic [15:0] lng, input logic ab,
                                  input logic sw, input logic frc);
        drain_results();
        write_word(REG_STEPS, {12'($urandom()), steps});
        write_word(REG_DEBOUNCE, deb);
        write_word(REG_LONG, lng);
        write_word(REG_AB_LOW, {15'($urandom()), ab});
        write_word(REG_SW_LOW, {15'($urandom()), sw});
        write_word(REG_FORCE_LOW, {15'($urandom()), frc});
        write_word(($urandom_range(1) != 0) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom()));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [3:0] steps, input logic [15:0] deb,
                             input logic [15:0] lng, input logic ab, input logic sw,
                             input logic frc, input int max_run, input int count);
        apply_settings(steps, deb, lng, ab, sw, frc);
        sw_run_max = max_run;
        repeat (count)
            send_request(next_sample());
    endtask

    initial
    begin : stimulus
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_STEPS;
        cfg_data  <= '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: priming sample, one detent each way, a reversal, a skipped state
        send_pins(1'b1, 1'b1, 1'b1, 1'b0);
        send_pins(1'b0, 1'b1, 1'b1, 1'b1);
        send_pins(1'b0, 1'b0, 1'b1, 1'b0);
        send_pins(1'b1, 1'b0, 1'b1, 1'b1);
        send_pins(1'b1, 1'b1, 1'b1, 1'b1);
        send_pins(1'b1, 1'b0, 1'b1, 1'b0);
        send_pins(1'b0, 1'b0, 1'b1, 1'b1);
        send_pins(1'b0, 1'b1, 1'b1, 1'b0);
        send_pins(1'b1, 1'b1, 1'b1, 1'b1);
        send_pins(1'b0, 1'b1, 1'b1, 1'b1);
        send_pins(1'b0, 1'b0, 1'b1, 1'b1);
        send_pins(1'b0, 1'b1, 1'b1, 1'b0);
        send_pins(1'b1, 1'b0, 1'b1, 1'b1);

        // Both level registers clear: pins fall back to active low.
        // Long press that swallows a detent, release after it, then a short press.
        apply_settings(4'd1, 16'd1, 16'd2, 1'b0, 1'b0, 1'b0);
        send_pins(1'b1, 1'b1, 1'b1, 1'b1);
        send_pins(1'b1, 1'b1, 1'b0, 1'b1);
        send_pins(1'b1, 1'b1, 1'b0, 1'b1);
        send_pins(1'b1, 1'b1, 1'b0, 1'b1);
        send_pins(1'b0, 1'b1, 1'b0, 1'b1);
        send_pins(1'b0, 1'b1, 1'b1, 1'b1);
        send_pins(1'b0, 1'b1, 1'b1, 1'b1);
        send_pins(1'b0, 1'b1, 1'b0, 1'b1);
        send_pins(1'b0, 1'b1, 1'b0, 1'b1);
        send_pins(1'b0, 1'b1, 1'b1, 1'b1);
        send_pins(1'b0, 1'b1, 1'b1, 1'b1);

        run_phase(4'd1, 16'd1, 16'd5, 1'b1, 1'b0, 1'b0, 12, 300);
        run_phase(4'd15, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1, 40, 250);
        run_phase(4'd0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b0, 80, 300);
        run_phase(4'd2, 16'd3, 16'd20, 1'b0, 1'b0, 1'b0, 40, 300);
        run_phase(4'($urandom_range(15)), 16'($urandom_range(1, 8)),
                  16'($urandom_range(1, 60)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 50, 300);
        run_phase(4'd3, 16'd2, 16'd1, 1'b1, 1'b1, 1'b1, 20, 300);

        drain_results();
        repeat (8)
            @(posedge clk);
        if (tracker.mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : result_sink
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                tracker.check_event(out_data);
            // hold off once for a long stretch so the block backs up into its input
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && sent_count >= 700)
            begin
                hold_done = 1'b1;
                hold_left = HoldOffCycles;
                out_stall <= 1'b1;
            end
            else if (calm_window())
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 26);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, QuietLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[rotary_encoder_with_button_unit.f]
rtl/rebd_pkg.sv
rtl/rotary_encoder_with_button_unit.sv
rtl/rebd_checker.sv
tb/tb_rotary_encoder_with_button_unit.sv
